[sv/opbg_pkg.sv]
// Package for the output pulse and blink generator: sizes, codes and shared types.
package opbg_pkg;

    localparam int CHANNELS    = 8;
    localparam int TIME_WIDTH  = 24;
    localparam int COUNT_WIDTH = 16;
    localparam int MASK_WIDTH  = 8;
    localparam int CHAN_WIDTH  = 4;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_PULSE    = 2'd1,
        CMD_BLINK    = 2'd2,
        CMD_SAFE_OFF = 2'd3
    } opbg_cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADARG = 2'd1,
        ST_NOTOUT = 2'd2
    } opbg_status_t;

    typedef struct packed {
        logic                   pulse_level;
        logic [TIME_WIDTH-1:0]  pulse_ticks;
        logic [TIME_WIDTH-1:0]  on_ticks;
        logic [TIME_WIDTH-1:0]  off_ticks;
        logic [COUNT_WIDTH-1:0] flash_count;
        logic                   final_level;
    } opbg_args_t;

    typedef struct packed {
        opbg_cmd_t             command;
        logic [CHAN_WIDTH-1:0] channel;
        opbg_args_t            args;
    } opbg_item_t;

    typedef struct packed {
        logic tick;
        logic safe_off;
        logic start_pulse;
        logic start_blink;
    } opbg_chan_ctl_t;

    typedef struct packed {
        logic level;
        logic pulse_busy;
        logic blink_busy;
    } opbg_chan_view_t;

endpackage

[sv/opbg_chan.sv]
// One output channel: pulse and blink state with its per-transfer update.
module opbg_chan (
    input  logic                    clk,
    input  logic                    rst_n,
    input  opbg_pkg::opbg_chan_ctl_t ctl,
    input  opbg_pkg::opbg_args_t    args,
    output opbg_pkg::opbg_chan_view_t cur,
    output opbg_pkg::opbg_chan_view_t nxt
);

    logic                              level_reg, level_next;
    logic                              pulse_run_reg, pulse_run_next;
    logic                              restore_reg, restore_next;
    logic [opbg_pkg::TIME_WIDTH-1:0]   pulse_left_reg, pulse_left_next;
    logic                              blink_run_reg, blink_run_next;
    logic                              on_phase_reg, on_phase_next;
    logic [opbg_pkg::COUNT_WIDTH-1:0]  flashes_reg, flashes_next;
    logic                              endless_reg, endless_next;
    logic [opbg_pkg::TIME_WIDTH-1:0]   on_len_reg, on_len_next;
    logic [opbg_pkg::TIME_WIDTH-1:0]   off_len_reg, off_len_next;
    logic [opbg_pkg::TIME_WIDTH-1:0]   phase_left_reg, phase_left_next;
    logic                              end_level_reg, end_level_next;

    logic [opbg_pkg::TIME_WIDTH-1:0]   pl_dec;
    logic [opbg_pkg::TIME_WIDTH-1:0]   ph_dec;
    logic [opbg_pkg::COUNT_WIDTH-1:0]  fl_dec;

    // saturating decrements
    assign pl_dec = (pulse_left_reg != '0) ? pulse_left_reg - 1'b1 : pulse_left_reg;
    assign ph_dec = (phase_left_reg != '0) ? phase_left_reg - 1'b1 : phase_left_reg;
    assign fl_dec = (!endless_reg && flashes_reg != '0) ? flashes_reg - 1'b1 : flashes_reg;

    always_comb
    begin
        level_next      = level_reg;
        pulse_run_next  = pulse_run_reg;
        restore_next    = restore_reg;
        pulse_left_next = pulse_left_reg;
        blink_run_next  = blink_run_reg;
        on_phase_next   = on_phase_reg;
        flashes_next    = flashes_reg;
        endless_next    = endless_reg;
        on_len_next     = on_len_reg;
        off_len_next    = off_len_reg;
        phase_left_next = phase_left_reg;
        end_level_next  = end_level_reg;

        if (ctl.tick)
        begin
            if (pulse_run_reg)
            begin
                pulse_left_next = pl_dec;
                if (pl_dec == '0)
                begin
                    pulse_run_next = 1'b0;
                    level_next     = restore_reg;
                end
            end
            if (blink_run_reg)
            begin
                phase_left_next = ph_dec;
                if (ph_dec == '0)
                begin
                    if (on_phase_reg)
                    begin
                        level_next      = 1'b0;
                        on_phase_next   = 1'b0;
                        phase_left_next = off_len_reg;
                    end
                    else
                    begin
                        flashes_next = fl_dec;
                        if (!endless_reg && fl_dec == '0)
                        begin
                            blink_run_next = 1'b0;
                            level_next     = end_level_reg;
                        end
                        else
                        begin
                            level_next      = 1'b1;
                            on_phase_next   = 1'b1;
                            phase_left_next = on_len_reg;
                        end
                    end
                end
            end
        end
        else if (ctl.safe_off || ctl.start_pulse || ctl.start_blink)
        begin
            pulse_run_next = 1'b0;
            blink_run_next = 1'b0;
            on_phase_next  = 1'b0;
            flashes_next   = '0;
            endless_next   = 1'b0;
            if (ctl.safe_off)
            begin
                level_next = 1'b0;
            end
            else if (ctl.start_pulse)
            begin
                restore_next    = level_reg;
                level_next      = args.pulse_level;
                pulse_run_next  = 1'b1;
                pulse_left_next = args.pulse_ticks;
            end
            else
            begin
                blink_run_next  = 1'b1;
                on_phase_next   = 1'b1;
                on_len_next     = args.on_ticks;
                off_len_next    = args.off_ticks;
                endless_next    = (args.flash_count == '0);
                flashes_next    = args.flash_count;
                end_level_next  = args.final_level;
                phase_left_next = args.on_ticks;
                level_next      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg      <= 1'b0;
            pulse_run_reg  <= 1'b0;
            restore_reg    <= 1'b0;
            pulse_left_reg <= '0;
            blink_run_reg  <= 1'b0;
            on_phase_reg   <= 1'b0;
            flashes_reg    <= '0;
            endless_reg    <= 1'b0;
            on_len_reg     <= '0;
            off_len_reg    <= '0;
            phase_left_reg <= '0;
            end_level_reg  <= 1'b0;
        end
        else
        begin
            level_reg      <= level_next;
            pulse_run_reg  <= pulse_run_next;
            restore_reg    <= restore_next;
            pulse_left_reg <= pulse_left_next;
            blink_run_reg  <= blink_run_next;
            on_phase_reg   <= on_phase_next;
            flashes_reg    <= flashes_next;
            endless_reg    <= endless_next;
            on_len_reg     <= on_len_next;
            off_len_reg    <= off_len_next;
            phase_left_reg <= phase_left_next;
            end_level_reg  <= end_level_next;
        end
    end

    assign cur.level      = level_reg;
    assign cur.pulse_busy = pulse_run_reg;
    assign cur.blink_busy = blink_run_reg;
    assign nxt.level      = level_next;
    assign nxt.pulse_busy = pulse_run_next;
    assign nxt.blink_busy = blink_run_next;

endmodule

[sv/output_pulse_blink_generator.sv]
// Top level of the output pulse and blink generator: input stage, command decode, result register.
//
//   channel   signals                                         direction
//   in        in_valid/in_ready, command..final_level         transfer into block
//   out       out_valid/out_ready, status..blink_busy         transfer out of block
//   cfg       cfg_wr_en, cfg_wr_data                          register write, no wait
//
// Result is registered after the input stage; one item per cycle sustained while out_ready holds.
// Every channel decodes the item in parallel in the cycle the item leaves the input stage.
// Reset clears all channel state, the enable mask and both valid flags.
// An output stall holds the result; one more item waits in the input stage.
module output_pulse_blink_generator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [opbg_pkg::MASK_WIDTH-1:0]     cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          command,
    input  logic [opbg_pkg::CHAN_WIDTH-1:0]     channel,
    input  logic                                pulse_level,
    input  logic [opbg_pkg::TIME_WIDTH-1:0]     pulse_ticks,
    input  logic [opbg_pkg::TIME_WIDTH-1:0]     on_ticks,
    input  logic [opbg_pkg::TIME_WIDTH-1:0]     off_ticks,
    input  logic [opbg_pkg::COUNT_WIDTH-1:0]    flash_count,
    input  logic                                final_level,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic [opbg_pkg::MASK_WIDTH-1:0]     line_levels,
    output logic [opbg_pkg::MASK_WIDTH-1:0]     pulse_busy,
    output logic [opbg_pkg::MASK_WIDTH-1:0]     blink_busy
);

    logic [opbg_pkg::MASK_WIDTH-1:0]  mask_reg;
    logic                             stage_valid_reg;
    opbg_pkg::opbg_item_t             item_reg;
    logic                             out_valid_reg;
    opbg_pkg::opbg_status_t           status_reg;
    logic [opbg_pkg::MASK_WIDTH-1:0]  levels_reg;
    logic [opbg_pkg::MASK_WIDTH-1:0]  pbusy_reg;
    logic [opbg_pkg::MASK_WIDTH-1:0]  bbusy_reg;

    logic                             fire;
    logic [opbg_pkg::CHAN_WIDTH-1:0]  ch_idx;
    logic                             ch_ok;
    logic                             arg_ok;
    logic                             ch_enabled;
    logic                             is_start;
    opbg_pkg::opbg_status_t           status_next;
    logic [opbg_pkg::MASK_WIDTH-1:0]  levels_cur, levels_next;
    logic [opbg_pkg::MASK_WIDTH-1:0]  pbusy_cur, pbusy_next;
    logic [opbg_pkg::MASK_WIDTH-1:0]  bbusy_cur, bbusy_next;

    assign fire     = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || fire;

    // command decode
    assign ch_idx   = item_reg.channel - 1'b1;
    assign ch_ok    = (item_reg.channel != '0) &&
                      (item_reg.channel <= opbg_pkg::CHAN_WIDTH'(opbg_pkg::CHANNELS));
    assign arg_ok   = (item_reg.command == opbg_pkg::CMD_PULSE) ?
                      (item_reg.args.pulse_ticks != '0) :
                      (item_reg.args.on_ticks != '0 && item_reg.args.off_ticks != '0);
    assign ch_enabled = (ch_idx < opbg_pkg::CHAN_WIDTH'(opbg_pkg::MASK_WIDTH)) &&
                        mask_reg[ch_idx[$clog2(opbg_pkg::MASK_WIDTH)-1:0]];
    assign is_start = (item_reg.command == opbg_pkg::CMD_PULSE) ||
                      (item_reg.command == opbg_pkg::CMD_BLINK);

    always_comb
    begin
        status_next = opbg_pkg::ST_OK;
        if (is_start)
        begin
            if (!ch_ok || !arg_ok)
            begin
                status_next = opbg_pkg::ST_BADARG;
            end
            else if (!ch_enabled)
            begin
                status_next = opbg_pkg::ST_NOTOUT;
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < opbg_pkg::CHANNELS; gi++)
        begin : g_chan
            opbg_pkg::opbg_chan_ctl_t  ctl;
            opbg_pkg::opbg_chan_view_t cur;
            opbg_pkg::opbg_chan_view_t nxt;
            logic                      hit;
            logic                      en;

            if (gi < opbg_pkg::MASK_WIDTH)
            begin : g_en
                assign en = mask_reg[gi];
            end
            else
            begin : g_noen
                assign en = 1'b0;
            end

            assign hit = fire && is_start && (status_next == opbg_pkg::ST_OK) &&
                         (ch_idx == opbg_pkg::CHAN_WIDTH'(gi));
            assign ctl.tick        = fire && (item_reg.command == opbg_pkg::CMD_TICK);
            assign ctl.safe_off    = fire && (item_reg.command == opbg_pkg::CMD_SAFE_OFF) && en;
            assign ctl.start_pulse = hit && (item_reg.command == opbg_pkg::CMD_PULSE);
            assign ctl.start_blink = hit && (item_reg.command == opbg_pkg::CMD_BLINK);

            opbg_chan u_chan (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (ctl),
                .args  (item_reg.args),
                .cur   (cur),
                .nxt   (nxt)
            );
        end

        for (gi = 0; gi < opbg_pkg::MASK_WIDTH; gi++)
        begin : g_view
            if (gi < opbg_pkg::CHANNELS)
            begin : g_live
                assign levels_cur[gi]  = g_chan[gi].cur.level;
                assign pbusy_cur[gi]   = g_chan[gi].cur.pulse_busy;
                assign bbusy_cur[gi]   = g_chan[gi].cur.blink_busy;
                assign levels_next[gi] = g_chan[gi].nxt.level;
                assign pbusy_next[gi]  = g_chan[gi].nxt.pulse_busy;
                assign bbusy_next[gi]  = g_chan[gi].nxt.blink_busy;
            end
            else
            begin : g_none
                assign levels_cur[gi]  = 1'b0;
                assign pbusy_cur[gi]   = 1'b0;
                assign bbusy_cur[gi]   = 1'b0;
                assign levels_next[gi] = 1'b0;
                assign pbusy_next[gi]  = 1'b0;
                assign bbusy_next[gi]  = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg        <= '0;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mask_reg <= cfg_wr_data;
            end
            if (in_ready)
            begin
                stage_valid_reg <= in_valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.command          <= opbg_pkg::opbg_cmd_t'(command);
            item_reg.channel          <= channel;
            item_reg.args.pulse_level <= pulse_level;
            item_reg.args.pulse_ticks <= pulse_ticks;
            item_reg.args.on_ticks    <= on_ticks;
            item_reg.args.off_ticks   <= off_ticks;
            item_reg.args.flash_count <= flash_count;
            item_reg.args.final_level <= final_level;
        end
        if (fire)
        begin
            status_reg <= status_next;
            levels_reg <= levels_next;
            pbusy_reg  <= pbusy_next;
            bbusy_reg  <= bbusy_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign line_levels = levels_reg;
    assign pulse_busy  = pbusy_reg;
    assign blink_busy  = bbusy_reg;

    // a channel never runs a pulse and a blink at once
    a_one_effect: assert property (@(posedge clk) disable iff (!rst_n)
        (pbusy_cur & bbusy_cur) == '0)
        else $error("pulse and blink both running on one channel");

    // rejected commands leave every channel untouched
    a_reject_stable: assert property (@(posedge clk) disable iff (!rst_n)
        fire && status_next != opbg_pkg::ST_OK |=>
        $stable(levels_cur) && $stable(pbusy_cur) && $stable(bbusy_cur))
        else $error("rejected command changed channel state");

    // safe off drives all enabled lines low and stops their effects
    a_safe_off: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item_reg.command == opbg_pkg::CMD_SAFE_OFF |=>
        ((levels_cur | pbusy_cur | bbusy_cur) & $past(mask_reg)) == '0)
        else $error("safe off left an enabled line active");

    // an empty result register never blocks input
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

    // the result levels and pulse busy flags match the channel state they were taken from
    a_result_state: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> levels_reg == levels_cur && pbusy_reg == pbusy_cur)
        else $error("result register out of step with channel state");

endmodule
